// File: hw/rtl/hcd_pkg.sv
// Package: shared types, character codes and sizing constants of the chunked decoder.
`default_nettype none

package hcd_pkg;

  // Default width of the chunk size arithmetic; magnitudes saturate at 2^(SIZE_BITS-1)-1.
  localparam int SIZE_BITS_DEFAULT = 32;

  // Depth of the queue between front and back (power of two).
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // One raw body byte as it arrives.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_body;
  } in_t;

  // One decoded result.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        is_data;
    logic [2:0]  status;
    logic [31:0] discard_count;
    logic        last_item;
  } out_t;

  // A classified byte on its way from front to back.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_body;
    logic       lone_lf;
  } entry_t;

endpackage

`default_nettype wire

// File: hw/rtl/hcd_front.sv
// Front end: accepts raw body bytes and marks each LF that lacks a preceding CR.
`default_nettype none

module hcd_front
  import hcd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   body_valid,
  output logic        body_stall,
  input  wire in_t    body,
  input  wire logic   q_ready,
  output logic        q_push,
  output entry_t      q_entry
);

  logic prev_was_cr;

  assign body_stall = !q_ready;
  assign q_push     = body_valid && q_ready;

  always_comb begin
    q_entry.in_byte     = body.in_byte;
    q_entry.end_of_body = body.end_of_body;
    q_entry.lone_lf     = (body.in_byte == CH_LF) && !prev_was_cr;
  end

  // Drop the CR history at the end of a body: the next byte starts a new one.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_was_cr <= 1'b0;
    end else if (q_push) begin
      prev_was_cr <= body.end_of_body ? 1'b0 : (body.in_byte == CH_CR);
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/hcd_queue.sv
// Short register queue that decouples the front end from the chunk parser.
`default_nettype none

module hcd_queue
  import hcd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_entry,
  output logic        ready,
  input  wire logic   pop,
  output logic        head_valid,
  output entry_t      head
);

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic [QPTR_W:0]   count_next;

  assign ready      = (count != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (!push && pop) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/hcd_back.sv
// Back end: chunk size parser, payload counter, status generation and output register.
`default_nettype none

module hcd_back
  import hcd_pkg::*;
#(
  parameter int SIZE_BITS = SIZE_BITS_DEFAULT
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   head_valid,
  input  wire entry_t head,
  output logic        pop,
  output logic        result_valid,
  input  wire logic   result_stall,
  output out_t        result
);

  localparam int DW = SIZE_BITS - 1;

  localparam logic [1:0] PH_SIZE = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_SKIP = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  localparam logic [2:0] ST_LEAD   = 3'd0;
  localparam logic [2:0] ST_SIGNED = 3'd1;
  localparam logic [2:0] ST_ZERO   = 3'd2;
  localparam logic [2:0] ST_DIGITS = 3'd3;
  localparam logic [2:0] ST_STOP   = 3'd4;

  localparam logic [1:0] SUB_FIRST  = 2'd0;
  localparam logic [1:0] SUB_LF     = 2'd1;
  localparam logic [1:0] SUB_STATUS = 2'd2;

  localparam logic [2:0] STS_NONE      = 3'd0;
  localparam logic [2:0] STS_ZERO_END  = 3'd1;
  localparam logic [2:0] STS_IN_LINE   = 3'd2;
  localparam logic [2:0] STS_CUT_SHORT = 3'd3;
  localparam logic [2:0] STS_NEGATIVE  = 3'd4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_XL    = 8'h78;
  localparam logic [7:0] CH_XU    = 8'h58;

  // Bit 4 flags a hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  logic [1:0]    phase, phase_next;
  logic [2:0]    step, step_next;
  logic          size_negative, size_negative_next;
  logic [DW-1:0] size_value, size_value_next;
  logic [DW-1:0] bytes_left, bytes_left_next;
  logic [DW-1:0] bytes_emitted, bytes_emitted_next;
  logic          pending_cr, pending_cr_next;
  logic [1:0]    trailer_skip, trailer_skip_next;
  logic [1:0]    sub, sub_next;

  logic          adv;
  logic          emit;
  out_t          emit_item;
  logic [7:0]    feed_c;
  logic [4:0]    hex;
  logic [DW+3:0] acc;
  logic [DW-1:0] digit_value;
  logic          blank;
  logic [2:0]    s;
  logic [1:0]    t;
  logic          take_signed;
  logic          take_digits;
  logic [31:0]   emitted_wide;

  // Each step emits at most one item, so advance only when the output register is free.
  assign adv = head_valid && (!result_valid || !result_stall);

  assign feed_c = (sub == SUB_LF) ? CH_LF : (head.lone_lf ? CH_CR : head.in_byte);
  assign hex    = hex_decode(feed_c);
  assign blank  = (feed_c == CH_SPACE) || (feed_c >= 8'h09 && feed_c <= 8'h0D);

  // Saturate when the shifted value plus digit leaves the magnitude range.
  assign acc          = {size_value, 4'b0000} + (DW + 4)'(hex[3:0]);
  assign digit_value  = (|acc[DW+3:DW]) ? '1 : acc[DW-1:0];
  assign emitted_wide = 32'(bytes_emitted);

  always_comb begin
    phase_next         = phase;
    step_next          = step;
    size_negative_next = size_negative;
    size_value_next    = size_value;
    bytes_left_next    = bytes_left;
    bytes_emitted_next = bytes_emitted;
    pending_cr_next    = pending_cr;
    trailer_skip_next  = trailer_skip;
    sub_next           = sub;
    pop                = 1'b0;
    emit               = 1'b0;
    emit_item          = '0;
    s                  = step;
    t                  = trailer_skip;
    take_signed        = 1'b0;
    take_digits        = 1'b0;

    if (adv && sub != SUB_STATUS) begin
      unique case (phase)
        PH_SIZE: begin
          if (pending_cr && feed_c == CH_LF) begin
            pending_cr_next = 1'b0;
            if (size_value == '0) begin
              size_negative_next = 1'b0;
              phase_next         = PH_DONE;
            end else if (size_negative) begin
              phase_next = PH_DONE;
            end else begin
              phase_next         = PH_DATA;
              bytes_left_next    = size_value;
              bytes_emitted_next = '0;
              size_value_next    = '0;
              step_next          = ST_LEAD;
            end
          end else begin
            // A held CR that no LF follows acts as a blank.
            if (pending_cr) begin
              s = (step == ST_LEAD) ? ST_LEAD : ST_STOP;
            end
            step_next = s;
            if (feed_c == CH_CR) begin
              pending_cr_next = 1'b1;
            end else begin
              pending_cr_next = 1'b0;
              unique case (s)
                ST_LEAD: begin
                  if (blank) begin
                    step_next = s;
                  end else if (feed_c == CH_PLUS || feed_c == CH_MINUS) begin
                    size_negative_next = (feed_c == CH_MINUS);
                    step_next          = ST_SIGNED;
                  end else begin
                    take_signed = 1'b1;
                  end
                end
                ST_SIGNED: take_signed = 1'b1;
                ST_ZERO: begin
                  if (feed_c == CH_XL || feed_c == CH_XU) begin
                    step_next = ST_DIGITS;
                  end else begin
                    take_digits = 1'b1;
                  end
                end
                ST_DIGITS: take_digits = 1'b1;
                default: step_next = s;
              endcase
              if (take_signed && feed_c == CH_ZERO) begin
                step_next = ST_ZERO;
              end else if (take_signed || take_digits) begin
                if (hex[4]) begin
                  size_value_next = digit_value;
                  step_next       = ST_DIGITS;
                end else begin
                  step_next = ST_STOP;
                end
              end
            end
          end
        end
        PH_DATA: begin
          bytes_left_next    = bytes_left - 1'b1;
          bytes_emitted_next = bytes_emitted + 1'b1;
          if (bytes_left == DW'(1)) begin
            phase_next        = PH_SKIP;
            trailer_skip_next = 2'd2;
          end
        end
        PH_SKIP: begin
          if (t != 2'd0) begin
            t = t - 1'b1;
          end
          trailer_skip_next = t;
          if (t == 2'd0) begin
            phase_next         = PH_SIZE;
            step_next          = ST_LEAD;
            size_negative_next = 1'b0;
            size_value_next    = '0;
            pending_cr_next    = 1'b0;
          end
        end
        default: begin
        end
      endcase

      if (phase == PH_DATA) begin
        emit                = 1'b1;
        emit_item.data_byte = feed_c;
        emit_item.is_data   = 1'b1;
        emit_item.status    = STS_NONE;
        // The LF half of a lone LF produces a byte only if the CR left the chunk open.
        if (sub == SUB_FIRST) begin
          emit_item.last_item = !(head.lone_lf && phase_next == PH_DATA) && !head.end_of_body;
        end else begin
          emit_item.last_item = !head.end_of_body;
        end
      end

      if (sub == SUB_FIRST && head.lone_lf) begin
        sub_next = SUB_LF;
      end else if (head.end_of_body) begin
        sub_next = SUB_STATUS;
      end else begin
        sub_next = SUB_FIRST;
        pop      = 1'b1;
      end
    end else if (adv) begin
      emit                = 1'b1;
      emit_item.is_data   = 1'b0;
      emit_item.last_item = 1'b1;
      if (phase == PH_DONE) begin
        emit_item.status = size_negative ? STS_NEGATIVE : STS_ZERO_END;
      end else if (phase == PH_DATA) begin
        emit_item.status        = STS_CUT_SHORT;
        emit_item.discard_count = emitted_wide;
      end else begin
        emit_item.status = STS_IN_LINE;
      end
      // Return to the reset state for the next body.
      phase_next         = PH_SIZE;
      step_next          = ST_LEAD;
      size_negative_next = 1'b0;
      size_value_next    = '0;
      bytes_left_next    = '0;
      bytes_emitted_next = '0;
      pending_cr_next    = 1'b0;
      trailer_skip_next  = 2'd0;
      sub_next           = SUB_FIRST;
      pop                = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SIZE;
      step          <= ST_LEAD;
      size_negative <= 1'b0;
      size_value    <= '0;
      bytes_left    <= '0;
      bytes_emitted <= '0;
      pending_cr    <= 1'b0;
      trailer_skip  <= 2'd0;
      sub           <= SUB_FIRST;
      result_valid  <= 1'b0;
    end else begin
      phase         <= phase_next;
      step          <= step_next;
      size_negative <= size_negative_next;
      size_value    <= size_value_next;
      bytes_left    <= bytes_left_next;
      bytes_emitted <= bytes_emitted_next;
      pending_cr    <= pending_cr_next;
      trailer_skip  <= trailer_skip_next;
      sub           <= sub_next;
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= emit_item;
    end
  end

  a_lf_step_needs_lone_lf: assert property (@(posedge clk) disable iff (rst)
    (sub == SUB_LF) |-> (head_valid && head.lone_lf))
    else $error("LF step without a lone LF at the queue head");

  a_status_step_needs_eob: assert property (@(posedge clk) disable iff (rst)
    (sub == SUB_STATUS) |-> (head_valid && head.end_of_body))
    else $error("status step without end of body at the queue head");

  a_status_resets_parser: assert property (@(posedge clk) disable iff (rst)
    (adv && sub == SUB_STATUS) |=> (phase == PH_SIZE && step == ST_LEAD && sub == SUB_FIRST))
    else $error("parser not back in reset state after a status item");

  a_data_has_no_status: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.is_data) |-> (result.status == STS_NONE))
    else $error("payload item carries a status code");

  a_skip_counter_live: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SKIP) |-> (trailer_skip != 2'd0))
    else $error("trailer skip phase with an empty skip count");

endmodule

`default_nettype wire

// File: hw/rtl/http_chunked_decoder_core.sv
// Top level of the streaming HTTP chunked transfer body decoder.
//
// The block takes one raw body byte per item on the body channel and returns decoded
// payload bytes and one status item per body on the result channel. A lone LF is first
// turned into CR LF, also inside chunk data, where both bytes pass out. A size line up to
// CR LF is read as a signed hex number (leading blanks, optional sign, optional 0x, digits,
// anything else ignored), saturating at 2^(SIZE_BITS-1)-1; that many bytes pass out and the
// next two are skipped. A zero size ends decoding, a negative one ends it with an error.
// The byte marked end_of_body always yields a status item (1 zero chunk, 2 ended in a size
// line or trailer, 3 chunk cut short with discard_count bytes already sent that should be
// thrown away, 4 negative size) and the decoder returns to its reset state. last_item marks
// the final result of each input byte; a byte may produce no result at all.
// Timing: the front end takes a byte every cycle while its two-entry queue has room. The
// parser in the back end handles a lone LF as a CR step followed by an LF step and gives an
// end-of-body byte one more step for the status item; a stream of ordinary bytes runs at
// one byte per cycle while the output is not stalled. The back end advances only while its
// output register is empty or being taken.
`default_nettype none

module http_chunked_decoder_core
  import hcd_pkg::*;
#(
  parameter int SIZE_BITS = SIZE_BITS_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic body_valid,
  output logic      body_stall,
  input  wire in_t  body,
  output logic      result_valid,
  input  wire logic result_stall,
  output out_t      result
);

  logic   q_ready;
  logic   q_push;
  entry_t q_entry;
  logic   q_pop;
  logic   q_head_valid;
  entry_t q_head;

  // Classify each byte and hold the CR history.
  hcd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .body_valid (body_valid),
    .body_stall (body_stall),
    .body       (body),
    .q_ready    (q_ready),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  // Buffer classified bytes so input keeps flowing while the parser waits on the output.
  hcd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .ready      (q_ready),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // Parse sizes, count payload and report the ending.
  hcd_back #(
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (q_head_valid),
    .head         (q_head),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire
